FILE: rtl/core/compacting_list_with_search_defines.svh
// Assertion macros shared by the list RTL.
// No dependencies; include after the clock aclk and reset aresetn are declared.
`ifndef COMPACTING_LIST_WITH_SEARCH_DEFINES_SVH
`define COMPACTING_LIST_WITH_SEARCH_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define CLS_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define CLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/cls_pkg.sv
// Package for the compacting list: field widths, codes, sequencer states, byte mask.
// No dependencies.
`default_nettype none

package cls_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int ACTION_W  = 2;
    localparam int INDEX_W   = 6;
    localparam int VALUE_W   = 64;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 6;
    localparam int FILL_W    = 7;
    localparam int CFG_W     = 4;
    localparam int S_DATA_W  = 72;
    localparam int M_DATA_W  = 80;

    localparam logic [CFG_W-1:0] ELEM_BYTES_RST = 4'd4;

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_GET    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_FIND   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET,
        S_SHIFT,
        S_SCAN,
        S_RESP
    } state_t;

    // Byte-enable mask for the element size; zero acts as one, above eight as eight.
    function automatic logic [VALUE_W-1:0] elem_mask(input logic [CFG_W-1:0] nbytes);
        logic [CFG_W-1:0]   n;
        logic [VALUE_W-1:0] m;
        n = nbytes;
        m = '0;
        if (n == 4'd0) begin
            n = 4'd1;
        end
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < n) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/cls_ram.sv
// Entry store for the compacting list: one write port, one registered read port.
// Depends on cls_pkg for the entry width.
`default_nettype none

module cls_ram
    import cls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [AW-1:0]      wr_addr,
    input  wire logic [VALUE_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [AW-1:0]      rd_addr,
    output logic      [VALUE_W-1:0] rd_data
);

    logic [VALUE_W-1:0] mem_reg [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/cls_match.sv
// Shared compare unit: builds the element byte mask and tests masked equality.
// Depends on cls_pkg for widths and the mask function.
`default_nettype none

module cls_match
    import cls_pkg::*;
(
    input  wire logic [CFG_W-1:0]   elem_bytes,
    input  wire logic [VALUE_W-1:0] lhs,
    input  wire logic [VALUE_W-1:0] rhs,
    output logic      [VALUE_W-1:0] mask,
    output logic                    hit
);

    assign mask = elem_mask(elem_bytes);
    assign hit  = (((lhs ^ rhs) & mask) == '0);

endmodule

`default_nettype wire

FILE: rtl/core/compacting_list_with_search.sv
// Top level of the compacting list with search: sequencer, count and output register.
// Depends on cls_pkg, cls_ram, cls_match and compacting_list_with_search_defines.svh.
//
// Usage: each input beat carries one operation in s_tuser (append, get, remove,
// find) with the index and value in s_tdata. Every beat yields exactly one result
// beat on the m_ channel: status in m_tuser, data, position and fill level in m_tdata.
// element_bytes is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this. Append
// and any error go straight to the response step; get reads the entry; find reads
// from position 0 to a hit or the list end; remove moves each entry above the index
// down one place. The single read port of the entry store sets the pace: one entry
// is read, compared or moved per cycle. s_tready is high only in the idle state, so
// one operation is in flight at a time. A finished result sits in the output
// register; the next beat is accepted while it waits, and the following result
// holds in the sequencer until m_tready drains the register. Reset clears the
// count, the output valid and the sequencer, and sets element_bytes to 4; the entry
// store is not cleared, as only entries below the count are ever read.
`default_nettype none
`include "compacting_list_with_search_defines.svh"

module compacting_list_with_search
    import cls_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration: element_bytes
    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_W-1:0]    cfg_wr_data,
    // input beats
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [5:0] index, [69:6] value, [71:70] zero
    input  wire logic [ACTION_W-1:0] s_tuser,   // [1:0] action
    // result beats
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [63:0] data, [69:64] position,
                                                // [76:70] fill_level, [79:77] zero
    output logic [STATUS_W-1:0]      m_tuser    // [1:0] status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // wide enough for count+1 and for the fill level field
    localparam int XW = (CW + 1 > FILL_W) ? CW + 1 : FILL_W;

    // unpack input
    logic [INDEX_W-1:0] s_index;
    logic [VALUE_W-1:0] s_value;
    action_t            s_action;

    assign s_index  = s_tdata[INDEX_W-1:0];
    assign s_value  = s_tdata[INDEX_W +: VALUE_W];
    assign s_action = action_t'(s_tuser);

    // state
    state_t             state_reg,  state_next;
    logic [CW-1:0]      cnt_reg,    cnt_next;
    logic [AW-1:0]      ptr_reg,    ptr_next;
    logic [VALUE_W-1:0] value_reg,  value_next;
    logic [CFG_W-1:0]   ebytes_reg;
    status_t            res_status_reg, res_status_next;
    logic [VALUE_W-1:0] res_data_reg,   res_data_next;
    logic [AW-1:0]      res_pos_reg,    res_pos_next;
    logic               m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;

    // memory and compare unit hookup
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_wdata, ram_rdata;
    logic [VALUE_W-1:0] mask;
    logic               hit;
    logic               s_acc, out_load;

    // index arithmetic at common width
    logic [XW-1:0] idx_x, idx_p1_x, cnt_x, ptr_x, ptr_p1_x, ptr_p2_x, pos_x, depth_x;

    assign idx_x    = XW'(s_index);
    assign idx_p1_x = idx_x + XW'(1);
    assign cnt_x    = XW'(cnt_reg);
    assign ptr_x    = XW'(ptr_reg);
    assign ptr_p1_x = ptr_x + XW'(1);
    assign ptr_p2_x = ptr_x + XW'(2);
    assign pos_x    = XW'(res_pos_reg);
    assign depth_x  = XW'(DEPTH);

    // hold ready low while in reset so no beat is taken and dropped
    assign s_tready = aresetn && (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    cls_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    cls_match u_match (
        .elem_bytes (ebytes_reg),
        .lhs        (ram_rdata),
        .rhs        (value_reg),
        .mask       (mask),
        .hit        (hit)
    );

    // element size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ebytes_reg <= ELEM_BYTES_RST;
        end else if (cfg_wr_en) begin
            ebytes_reg <= cfg_wr_data;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // work registers, no reset needed
    always_ff @(posedge aclk) begin
        ptr_reg        <= ptr_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_pos_reg    <= res_pos_next;
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ptr_next        = ptr_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_pos_next    = res_pos_reg;
        ram_we          = 1'b0;
        ram_waddr       = ptr_reg;
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = ptr_p1_x[AW-1:0];
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    res_status_next = ST_OK;
                    res_data_next   = '0;
                    res_pos_next    = '0;
                    value_next      = s_value;
                    state_next      = S_RESP;
                    case (s_action)
                        ACT_APPEND: begin
                            if (cnt_x >= depth_x) begin
                                res_status_next = ST_FULL;
                            end else begin
                                // store only the low element bytes
                                ram_we    = 1'b1;
                                ram_waddr = cnt_reg[AW-1:0];
                                ram_wdata = s_value & mask;
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        ACT_GET: begin
                            if (idx_x >= cnt_x) begin
                                res_status_next = ST_RANGE;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = idx_x[AW-1:0];
                                state_next = S_GET;
                            end
                        end
                        ACT_REMOVE: begin
                            if (idx_x >= cnt_x) begin
                                res_status_next = ST_RANGE;
                            end else begin
                                ptr_next = idx_x[AW-1:0];
                                if (idx_p1_x < cnt_x) begin
                                    // fetch the first entry to move down
                                    ram_re     = 1'b1;
                                    ram_raddr  = idx_p1_x[AW-1:0];
                                    state_next = S_SHIFT;
                                end else begin
                                    cnt_next = cnt_reg - 1'b1;
                                end
                            end
                        end
                        ACT_FIND: begin
                            if (cnt_reg == '0) begin
                                res_status_next = ST_NOTFOUND;
                            end else begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                ptr_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_GET: begin
                res_data_next = ram_rdata & mask;
                state_next    = S_RESP;
            end
            S_SHIFT: begin
                // move entry ptr+1 into ptr, prefetch ptr+2
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                ptr_next  = ptr_p1_x[AW-1:0];
                if (ptr_p2_x < cnt_x) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_p2_x[AW-1:0];
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = S_RESP;
                end
            end
            S_SCAN: begin
                if (hit) begin
                    res_pos_next = ptr_reg;
                    state_next   = S_RESP;
                end else if (ptr_p1_x < cnt_x) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_p1_x[AW-1:0];
                    ptr_next  = ptr_p1_x[AW-1:0];
                end else begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_RESP;
                end
            end
            S_RESP: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= {(M_DATA_W - VALUE_W - POS_W - FILL_W)'(0),
                            cnt_x[FILL_W-1:0], pos_x[POS_W-1:0], res_data_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `CLS_ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_x <= depth_x, "entry count above depth")
    `CLS_ASSERT_NEXT(a_append_grows, s_acc && (s_action == ACT_APPEND) && (cnt_x < depth_x),
        cnt_reg == $past(cnt_reg) + 1'b1, "append did not grow the list")
    `CLS_ASSERT_IMPLY(a_full_only_at_depth, out_load && (res_status_reg == ST_FULL),
        cnt_x == depth_x, "full reported below depth")
    `CLS_ASSERT_IMPLY(a_result_from_resp, $rose(m_tvalid_reg), $past(state_reg == S_RESP),
        "result raised outside the response step")

endmodule

`default_nettype wire
